// ----- rtl/core/c8_pkg.sv -----
// ----------------------------------------------------------------------------
// c8_pkg: shared types and constants
// Request payloads, command codes, status codes and controller states.
// ----------------------------------------------------------------------------
package c8_pkg;

    localparam int unsigned STACK_DEPTH = 16;
    localparam int unsigned SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int unsigned STK_AW      = $clog2(STACK_DEPTH);
    localparam logic [7:0]  LFSR_TAPS   = 8'hB8;

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_EXEC    = 2'd1,
        CMD_READ    = 2'd2,
        CMD_RESTART = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_BAD_OP    = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [11:0] load_address;
        logic [7:0]  load_data;
        logic [4:0]  row_select;
    } t_in;

    typedef struct packed {
        logic [11:0] pc_value;
        logic [11:0] index_value;
        logic [7:0]  flag_value;
        logic [63:0] screen_row_bits;
        logic [1:0]  status;
    } t_out;

    typedef enum logic [4:0] {
        S_INIT, S_INIT_CLR,
        S_IDLE, S_F0, S_F1, S_F2, S_DEC, S_CLR,
        S_DR_RD, S_DR_WAIT, S_DR_FB, S_DR_WR,
        S_BCD, S_ST_RD, S_ST_WR, S_LD_RD, S_LD_WAIT, S_LD_WR,
        S_RET_RD, S_RET_WAIT, S_RD_FB, S_RD_WAIT, S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;    // Latch the request.
        logic do_load;    // Store the load byte.
        logic do_restart;
        logic mem_rd_pc;  // Read memory at PC (lo=0) or PC+1 (lo=1).
        logic mem_rd_lo;
        logic lat_hi;     // Latch opcode high byte.
        logic lat_lo;
        logic exec_simple;
        logic clr_start;
        logic clr_step;
        logic dr_start;
        logic dr_rd;      // Read sprite byte.
        logic dr_fb;      // Read frame buffer row.
        logic dr_wr;      // XOR and write row.
        logic bcd_step;
        logic blk_start;
        logic st_rd;
        logic st_wr;
        logic ld_rd;
        logic ld_wr;
        logic ret_rd;
        logic ret_fin;
        logic row_rd;
        logic row_fin;
        logic out_load;
    } t_ctl;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] cmd;
        logic [3:0] op_hi;
        logic       is_cls;
        logic       is_ret;
        logic       ret_empty;
        logic       is_draw;
        logic       is_bcd;
        logic       is_store;
        logic       is_loadblk;
        logic       last;    // Current walk ends after this step.
    } t_sts;

endpackage

// ----- rtl/core/c8_ctrl.sv -----
// ----------------------------------------------------------------------------
// c8_ctrl: command sequencer
// Steps execute requests through fetch, decode and multi-step operations; load, read and restart take shorter paths.
// ----------------------------------------------------------------------------
module c8_ctrl import c8_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic i_out_busy,
    input  t_sts i_sts,
    output logic o_stall,
    output t_ctl o_ctl
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_INIT;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        o_stall = (r_state != S_IDLE);
        case (r_state)
            S_INIT: begin
                o_ctl.clr_start = 1'b1;
                n_state = S_INIT_CLR;
            end
            S_INIT_CLR: begin
                o_ctl.clr_step = 1'b1;
                if (i_sts.last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_ctl.capture = 1'b1;
                    n_state = S_F0;
                end
            end
            S_F0: begin
                case (i_sts.cmd)
                    CMD_LOAD: begin
                        o_ctl.do_load = 1'b1;
                        n_state = S_DONE;
                    end
                    CMD_RESTART: begin
                        o_ctl.do_restart = 1'b1;
                        o_ctl.clr_start  = 1'b1;
                        n_state = S_CLR;
                    end
                    CMD_READ: n_state = S_RD_FB;
                    default: begin
                        o_ctl.mem_rd_pc = 1'b1;
                        n_state = S_F1;
                    end
                endcase
            end
            S_F1: begin
                o_ctl.mem_rd_pc = 1'b1;
                o_ctl.mem_rd_lo = 1'b1;
                o_ctl.lat_hi    = 1'b1;
                n_state = S_F2;
            end
            S_F2: begin
                o_ctl.lat_lo = 1'b1;
                n_state = S_DEC;
            end
            S_DEC: begin
                o_ctl.exec_simple = 1'b1;
                n_state = S_DONE;
                if (i_sts.is_cls) begin
                    o_ctl.clr_start = 1'b1;
                    n_state = S_CLR;
                end else if (i_sts.is_ret && !i_sts.ret_empty) begin
                    o_ctl.ret_rd = 1'b1;
                    n_state = S_RET_WAIT;
                end else if (i_sts.is_draw) begin
                    o_ctl.dr_start = 1'b1;
                    n_state = i_sts.last ? S_DONE : S_DR_RD;
                end else if (i_sts.is_bcd) begin
                    o_ctl.blk_start = 1'b1;
                    n_state = S_BCD;
                end else if (i_sts.is_store) begin
                    o_ctl.blk_start = 1'b1;
                    n_state = S_ST_RD;
                end else if (i_sts.is_loadblk) begin
                    o_ctl.blk_start = 1'b1;
                    n_state = S_LD_RD;
                end
            end
            S_CLR: begin
                o_ctl.clr_step = 1'b1;
                if (i_sts.last) n_state = S_DONE;
            end
            S_RET_WAIT: begin
                o_ctl.ret_fin = 1'b1;
                n_state = S_DONE;
            end
            S_DR_RD: begin
                o_ctl.dr_rd = 1'b1;
                n_state = S_DR_WAIT;
            end
            S_DR_WAIT: begin
                o_ctl.dr_fb = 1'b1;
                n_state = S_DR_FB;
            end
            S_DR_FB: n_state = S_DR_WR;
            S_DR_WR: begin
                o_ctl.dr_wr = 1'b1;
                n_state = i_sts.last ? S_DONE : S_DR_RD;
            end
            S_BCD: begin
                o_ctl.bcd_step = 1'b1;
                if (i_sts.last) n_state = S_DONE;
            end
            S_ST_RD: begin
                o_ctl.st_rd = 1'b1;
                n_state = S_ST_WR;
            end
            S_ST_WR: begin
                o_ctl.st_wr = 1'b1;
                n_state = i_sts.last ? S_DONE : S_ST_RD;
            end
            S_LD_RD: begin
                o_ctl.ld_rd = 1'b1;
                n_state = S_LD_WAIT;
            end
            S_LD_WAIT: n_state = S_LD_WR;
            S_LD_WR: begin
                o_ctl.ld_wr = 1'b1;
                n_state = i_sts.last ? S_DONE : S_LD_RD;
            end
            S_RD_FB: begin
                o_ctl.row_rd = 1'b1;
                n_state = S_RD_WAIT;
            end
            S_RD_WAIT: begin
                o_ctl.row_fin = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!i_out_busy) begin
                    o_ctl.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ----- rtl/core/c8_datapath.sv -----
// ----------------------------------------------------------------------------
// c8_datapath: registers, memories and execution units
// Holds program memory, frame buffer, stack, V registers, PC, I and LFSR.
// ----------------------------------------------------------------------------
module c8_datapath import c8_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_in         i_req,
    input  logic [11:0] i_start_address,
    input  t_ctl        i_ctl,
    output t_sts        o_sts,
    output t_out        o_res
);

    logic [7:0]  r_mem [4096];
    logic [63:0] r_fb  [32];
    logic [11:0] r_stk [STACK_DEPTH];

    t_in          r_req;
    logic [7:0]   r_v [16];
    logic [11:0]  r_pc, r_i;
    logic [SP_W-1:0] r_sp;
    logic [7:0]   r_lfsr;
    logic [15:0]  r_op;
    logic [1:0]   r_status;
    logic [7:0]   r_mrd;
    logic [63:0]  r_fbrd, r_row;
    logic [11:0]  r_stkrd;
    logic [4:0]   r_cnt;
    logic [4:0]   r_rowidx;
    logic [5:0]   r_ox;
    logic [3:0]   r_blk;
    logic [11:0]  r_addr;
    logic [7:0]   r_bcd;

    logic [3:0]  w_x, w_y, w_n;
    logic [7:0]  w_nn, w_vx, w_vy;
    logic [11:0] w_pc2;
    logic [8:0]  w_sum;
    logic [5:0]  w_h;
    logic [4:0]  w_rows;

    assign w_x   = r_op[11:8];
    assign w_y   = r_op[7:4];
    assign w_n   = r_op[3:0];
    assign w_nn  = r_op[7:0];
    assign w_vx  = r_v[w_x];
    assign w_vy  = r_v[w_y];
    assign w_pc2 = r_pc + 12'd2;
    assign w_sum = {1'b0, w_vx} + {1'b0, w_vy};
    // Rows drawable before the bottom edge.
    assign w_h    = 6'd32 - {1'b0, w_vy[4:0]};
    assign w_rows = ({2'b0, w_n} < w_h) ? {1'b0, w_n} : w_h[4:0];

    logic w_mem_we;
    logic [11:0] w_mem_wa, w_mem_ra;
    logic [7:0]  w_mem_wd;
    logic w_mem_re;

    // Decimal digits: hundreds by compare, tens by reciprocal multiply.
    logic [1:0]  w_bcd_h;
    logic [7:0]  w_bcd_r, w_bcd_t, w_bcd_o;
    logic [15:0] w_bcd_m;
    assign w_bcd_h = (r_bcd >= 8'd200) ? 2'd2 : (r_bcd >= 8'd100) ? 2'd1 : 2'd0;
    assign w_bcd_r = r_bcd - ((r_bcd >= 8'd200) ? 8'd200 :
                              (r_bcd >= 8'd100) ? 8'd100 : 8'd0);
    assign w_bcd_m = {8'd0, w_bcd_r} * 16'd205;
    assign w_bcd_t = {3'd0, w_bcd_m[15:11]};
    assign w_bcd_o = w_bcd_r - w_bcd_t * 8'd10;

    always_comb begin
        w_mem_we = 1'b0;
        w_mem_wa = r_addr;
        w_mem_wd = r_v[r_blk];
        w_mem_re = 1'b0;
        w_mem_ra = r_addr;
        if (i_ctl.do_load) begin
            w_mem_we = 1'b1;
            w_mem_wa = r_req.load_address;
            w_mem_wd = r_req.load_data;
        end else if (i_ctl.st_wr) begin
            w_mem_we = 1'b1;
        end else if (i_ctl.bcd_step) begin
            w_mem_we = 1'b1;
            w_mem_wd = (r_cnt == 5'd0) ? {6'd0, w_bcd_h} :
                       (r_cnt == 5'd1) ? w_bcd_t : w_bcd_o;
        end
        if (i_ctl.mem_rd_pc) begin
            w_mem_re = 1'b1;
            w_mem_ra = i_ctl.mem_rd_lo ? r_pc + 12'd1 : r_pc;
        end else if (i_ctl.dr_rd || i_ctl.ld_rd) begin
            w_mem_re = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) r_mem[w_mem_wa] <= w_mem_wd;
        if (w_mem_re) r_mrd <= r_mem[w_mem_ra];
    end

    // Frame buffer: one write port, one registered read port.
    logic        w_fb_we;
    logic [4:0]  w_fb_wa, w_fb_ra;
    logic [63:0] w_fb_wd, w_spr;
    assign w_spr = {r_mrd, 56'd0} >> r_ox;
    always_comb begin
        w_fb_we = 1'b0;
        w_fb_wa = r_cnt;
        w_fb_wd = '0;
        w_fb_ra = r_rowidx;
        if (i_ctl.clr_step) begin
            w_fb_we = 1'b1;
        end else if (i_ctl.dr_wr) begin
            w_fb_we = 1'b1;
            w_fb_wa = r_rowidx;
            w_fb_wd = r_fbrd ^ w_spr;
        end
        if (i_ctl.row_rd) w_fb_ra = r_req.row_select;
    end

    always_ff @(posedge i_clk) begin
        if (w_fb_we) r_fb[w_fb_wa] <= w_fb_wd;
        if (i_ctl.dr_fb || i_ctl.row_rd) r_fbrd <= r_fb[w_fb_ra];
    end

    // Return stack.
    logic w_push;
    assign w_push = i_ctl.exec_simple && r_op[15:12] == 4'h2 && r_sp < SP_W'(STACK_DEPTH);
    always_ff @(posedge i_clk) begin
        if (w_push) r_stk[r_sp[STK_AW-1:0]] <= w_pc2;
        if (i_ctl.ret_rd) r_stkrd <= r_stk[STK_AW'(r_sp - SP_W'(1))];
    end

    logic w_last;
    always_comb begin
        w_last = 1'b0;
        if (i_ctl.clr_step || i_ctl.clr_start) w_last = (r_cnt == 5'd31);
        else if (i_ctl.dr_start) w_last = (w_rows == 5'd0);
        else if (i_ctl.dr_wr) w_last = (r_cnt == 5'd1);
        else if (i_ctl.bcd_step) w_last = (r_cnt == 5'd2);
        else if (i_ctl.st_wr || i_ctl.ld_wr) w_last = (r_blk == w_x);
    end

    always_comb begin
        o_sts            = '0;
        o_sts.cmd        = r_req.cmd;
        o_sts.op_hi      = r_op[15:12];
        o_sts.is_cls     = (r_op == 16'h00E0);
        o_sts.is_ret     = (r_op == 16'h00EE);
        o_sts.ret_empty  = (r_sp == '0);
        o_sts.is_draw    = (r_op[15:12] == 4'hD);
        o_sts.is_bcd     = (r_op[15:12] == 4'hF) && (w_nn == 8'h33);
        o_sts.is_store   = (r_op[15:12] == 4'hF) && (w_nn == 8'h55);
        o_sts.is_loadblk = (r_op[15:12] == 4'hF) && (w_nn == 8'h65);
        o_sts.last       = w_last;
    end

    logic [7:0] w_lfsr_n;
    assign w_lfsr_n = r_lfsr[0] ? ((r_lfsr >> 1) ^ LFSR_TAPS) : (r_lfsr >> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc     <= 12'd512;
            r_i      <= '0;
            r_sp     <= '0;
            r_lfsr   <= 8'd1;
            r_status <= ST_OK;
            r_row    <= '0;
            for (int k = 0; k < 16; k++) r_v[k] <= '0;
        end else begin
            if (i_ctl.capture) begin
                r_status <= ST_OK;
                r_row    <= '0;
            end
            if (i_ctl.do_restart) begin
                r_pc   <= i_start_address;
                r_i    <= '0;
                r_sp   <= '0;
                r_lfsr <= 8'd1;
                for (int k = 0; k < 16; k++) r_v[k] <= '0;
            end
            if (i_ctl.exec_simple) begin
                r_pc <= w_pc2;
                case (r_op[15:12])
                    4'h0: begin
                        if (r_op == 16'h00EE) begin
                            if (r_sp == '0) r_status <= ST_UNDERFLOW;
                            else            r_sp <= r_sp - SP_W'(1);
                        end else if (r_op != 16'h00E0) begin
                            r_status <= ST_BAD_OP;
                        end
                    end
                    4'h1: r_pc <= r_op[11:0];
                    4'h2: begin
                        if (w_push) begin
                            r_sp <= r_sp + SP_W'(1);
                            r_pc <= r_op[11:0];
                        end else begin
                            r_status <= ST_OVERFLOW;
                        end
                    end
                    4'h3: if (w_vx == w_nn) r_pc <= r_pc + 12'd4;
                    4'h4: if (w_vx != w_nn) r_pc <= r_pc + 12'd4;
                    4'h5, 4'h9: begin
                        if (w_n != 4'd0) r_status <= ST_BAD_OP;
                        else if ((w_vx == w_vy) == (r_op[15:12] == 4'h5))
                            r_pc <= r_pc + 12'd4;
                    end
                    4'h6: r_v[w_x] <= w_nn;
                    4'h7: r_v[w_x] <= w_vx + w_nn;
                    4'h8: begin
                        case (w_n)
                            4'h0: r_v[w_x] <= w_vy;
                            4'h1: r_v[w_x] <= w_vx | w_vy;
                            4'h2: r_v[w_x] <= w_vx & w_vy;
                            4'h3: r_v[w_x] <= w_vx ^ w_vy;
                            4'h4: begin
                                r_v[w_x] <= w_sum[7:0];
                                r_v[15]  <= {7'd0, w_sum[8]};
                            end
                            4'h5: begin
                                r_v[w_x] <= w_vx - w_vy;
                                r_v[15]  <= {7'd0, w_vx >= w_vy};
                            end
                            4'h6: begin
                                r_v[w_x] <= w_vx >> 1;
                                r_v[15]  <= {7'd0, w_vx[0]};
                            end
                            4'h7: begin
                                r_v[w_x] <= w_vy - w_vx;
                                r_v[15]  <= {7'd0, w_vy >= w_vx};
                            end
                            4'hE: begin
                                r_v[w_x] <= {w_vx[6:0], 1'b0};
                                r_v[15]  <= {7'd0, w_vx[7]};
                            end
                            default: r_status <= ST_BAD_OP;
                        endcase
                    end
                    4'hA: r_i <= r_op[11:0];
                    4'hB: r_pc <= {4'd0, r_v[0]} + r_op[11:0];
                    4'hC: begin
                        r_lfsr   <= w_lfsr_n;
                        r_v[w_x] <= w_lfsr_n & w_nn;
                    end
                    4'hD: r_v[15] <= '0;
                    4'hE: if (w_nn != 8'h9E && w_nn != 8'hA1) r_status <= ST_BAD_OP;
                    default: begin
                        case (w_nn)
                            8'h07, 8'h0A, 8'h15, 8'h18, 8'h29, 8'h33, 8'h55, 8'h65: ;
                            8'h1E: r_i <= r_i + {4'd0, w_vx};
                            default: r_status <= ST_BAD_OP;
                        endcase
                    end
                endcase
            end
            if (i_ctl.ret_fin) r_pc <= r_stkrd;
            if (i_ctl.dr_wr && ((r_fbrd & w_spr) != '0)) r_v[15] <= 8'd1;
            if (i_ctl.ld_wr) r_v[r_blk] <= r_mrd;
            if (i_ctl.row_fin) r_row <= r_fbrd;
        end
    end

    // Sequencing registers; payload only.
    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) r_req <= i_req;
        if (i_ctl.lat_hi) r_op[15:8] <= r_mrd;
        if (i_ctl.lat_lo) r_op[7:0]  <= r_mrd;
        if (i_ctl.clr_start) r_cnt <= '0;
        if (i_ctl.clr_step)  r_cnt <= r_cnt + 5'd1;
        if (i_ctl.dr_start) begin
            r_cnt    <= w_rows;
            r_rowidx <= w_vy[4:0];
            r_ox     <= w_vx[5:0];
            r_addr   <= r_i;
        end
        if (i_ctl.dr_wr) begin
            r_cnt    <= r_cnt - 5'd1;
            r_rowidx <= r_rowidx + 5'd1;
            r_addr   <= r_addr + 12'd1;
        end
        if (i_ctl.blk_start) begin
            r_cnt  <= '0;
            r_blk  <= '0;
            r_addr <= r_i;
            r_bcd  <= w_vx;
        end
        if (i_ctl.bcd_step) begin
            r_cnt  <= r_cnt + 5'd1;
            r_addr <= r_addr + 12'd1;
        end
        if (i_ctl.st_wr || i_ctl.ld_wr) begin
            r_blk  <= r_blk + 4'd1;
            r_addr <= r_addr + 12'd1;
        end
    end

    assign o_res.pc_value        = r_pc;
    assign o_res.index_value     = r_i;
    assign o_res.flag_value      = r_v[15];
    assign o_res.screen_row_bits = r_row;
    assign o_res.status          = r_status;

endmodule

// ----- rtl/core/chip8_instruction_core.sv -----
// ----------------------------------------------------------------------------
// chip8_instruction_core: CHIP-8 execution core
// Channel   Direction  Handshake           Payload
// request   in         i_valid / o_stall   t_in
// result    out        o_valid / i_stall   t_out
// config    in         i_cfg_we            i_cfg_wdata (start address)
// Draw works row by row, block store and block load byte by byte, and restart
// and clear screen wipe the frame buffer (one frame buffer row per cycle).
// A result waits in the output register while the next request is taken in.
// Reset sets PC to 512 and clears registers and state machines; a pass then
// clears the frame buffer while the request stall is high.
// ----------------------------------------------------------------------------
module chip8_instruction_core import c8_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_in         i_req,
    output logic        o_valid,
    input  logic        i_stall,
    output t_out        o_res,
    input  logic        i_cfg_we,
    input  logic [11:0] i_cfg_wdata
);

    logic [11:0] r_start;
    logic        r_valid;
    t_out        r_res;
    t_ctl        w_ctl;
    t_sts        w_sts;
    t_out        w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)      r_start <= 12'd512;
        else if (i_cfg_we) r_start <= i_cfg_wdata;
    end

    c8_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_out_busy (r_valid && i_stall),
        .i_sts      (w_sts),
        .o_stall    (o_stall),
        .o_ctl      (w_ctl)
    );

    c8_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req           (i_req),
        .i_start_address (r_start),
        .i_ctl           (w_ctl),
        .o_sts           (w_sts),
        .o_res           (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_ctl.out_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.out_load) r_res <= w_res;
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.out_load |-> !(r_valid && i_stall))
        else $error("result register overwritten while stalled");

    a_capture_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.capture |-> !o_stall)
        else $error("request captured while stalled");

    a_status_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.status != ST_OK) |-> o_res.screen_row_bits == '0)
        else $error("status and row data both set");

endmodule

// ----- tb/chip8_instruction_core_test.sv -----
// ----------------------------------------------------------------------------
// chip8_instruction_core_test: self-checking bench for the CHIP-8 core
// Loads short programs, executes them, reads screen rows and restarts, and
// compares every result with a behavioral copy of the machine under several
// start addresses and idling patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module chip8_instruction_core_test;
    import c8_pkg::*;

    class c8_scoreboard;
        logic [11:0] start_addr;
        logic [7:0]  mem [4096];
        logic [7:0]  v [16];
        logic [11:0] pc;
        logic [11:0] ireg;
        logic [11:0] stk [STACK_DEPTH];
        int unsigned sp;
        logic [63:0] fb [32];
        logic [7:0]  lfsr;
        t_out        pending [$];
        int          errors;

        function new();
            start_addr = 12'd512;
            pc = 12'd512;
            errors = 0;
            foreach (mem[k]) mem[k] = 8'h00;
            clear_machine();
        endfunction

        function void clear_machine();
            foreach (v[k]) v[k] = 8'h00;
            foreach (fb[k]) fb[k] = 64'h0;
            ireg = 12'h0;
            sp = 0;
            lfsr = 8'h01;
        endfunction

        function t_status run_opcode();
            logic [15:0] op;
            logic [3:0] x, y, n;
            logic [7:0] nn, vx, vy, d;
            logic [8:0] sum;
            int ox, oy, row, col;
            op = {mem[pc], mem[pc + 12'd1]};
            x = op[11:8];
            y = op[7:4];
            n = op[3:0];
            nn = op[7:0];
            pc = pc + 12'd2;
            vx = v[x];
            vy = v[y];
            case (op[15:12])
                4'h0: begin
                    if (op == 16'h00E0) begin
                        foreach (fb[k]) fb[k] = 64'h0;
                    end else if (op == 16'h00EE) begin
                        if (sp == 0) return ST_UNDERFLOW;
                        sp--;
                        pc = stk[sp];
                    end else return ST_BAD_OP;
                end
                4'h1: pc = op[11:0];
                4'h2: begin
                    if (sp >= STACK_DEPTH) return ST_OVERFLOW;
                    stk[sp] = pc;
                    sp++;
                    pc = op[11:0];
                end
                4'h3: if (vx == nn) pc = pc + 12'd2;
                4'h4: if (vx != nn) pc = pc + 12'd2;
                4'h5, 4'h9: begin
                    if (n != 0) return ST_BAD_OP;
                    if ((vx == vy) == (op[15:12] == 4'h5)) pc = pc + 12'd2;
                end
                4'h6: v[x] = nn;
                4'h7: v[x] = vx + nn;
                4'h8: begin
                    case (n)
                        4'h0: v[x] = vy;
                        4'h1: v[x] = vx | vy;
                        4'h2: v[x] = vx & vy;
                        4'h3: v[x] = vx ^ vy;
                        4'h4: begin
                            sum = vx + vy;
                            v[x] = sum[7:0];
                            v[15] = {7'd0, sum[8]};
                        end
                        4'h5: begin
                            v[x] = vx - vy;
                            v[15] = {7'd0, vx >= vy};
                        end
                        4'h6: begin
                            v[x] = vx >> 1;
                            v[15] = {7'd0, vx[0]};
                        end
                        4'h7: begin
                            v[x] = vy - vx;
                            v[15] = {7'd0, vy >= vx};
                        end
                        4'hE: begin
                            v[x] = vx << 1;
                            v[15] = {7'd0, vx[7]};
                        end
                        default: return ST_BAD_OP;
                    endcase
                end
                4'hA: ireg = op[11:0];
                4'hB: pc = {4'h0, v[0]} + op[11:0];
                4'hC: begin
                    lfsr = lfsr[0] ? ((lfsr >> 1) ^ LFSR_TAPS) : (lfsr >> 1);
                    v[x] = lfsr & nn;
                end
                4'hD: begin
                    ox = vx % 64;
                    oy = vy % 32;
                    v[15] = 8'h00;
                    for (int h = 0; h < n; h++) begin
                        row = oy + h;
                        if (row < 32) begin
                            d = mem[ireg + h[11:0]];
                            for (int b = 0; b < 8; b++) begin
                                col = ox + b;
                                if (col < 64 && d[7 - b]) begin
                                    if (fb[row][63 - col]) v[15] = 8'h01;
                                    fb[row][63 - col] = ~fb[row][63 - col];
                                end
                            end
                        end
                    end
                end
                4'hE: if (nn != 8'h9E && nn != 8'hA1) return ST_BAD_OP;
                default: begin
                    case (nn)
                        8'h07, 8'h0A, 8'h15, 8'h18, 8'h29: ;
                        8'h1E: ireg = ireg + {4'h0, vx};
                        8'h33: begin
                            mem[ireg] = vx / 100;
                            mem[ireg + 12'd1] = (vx / 10) % 10;
                            mem[ireg + 12'd2] = vx % 10;
                        end
                        8'h55: for (int k = 0; k <= x; k++) mem[ireg + k[11:0]] = v[k];
                        8'h65: for (int k = 0; k <= x; k++) v[k] = mem[ireg + k[11:0]];
                        default: return ST_BAD_OP;
                    endcase
                end
            endcase
            return ST_OK;
        endfunction

        function void note_request(t_in req);
            t_out r;
            r = '0;
            case (t_cmd'(req.cmd))
                CMD_LOAD: mem[req.load_address] = req.load_data;
                CMD_EXEC: r.status = run_opcode();
                CMD_READ: r.screen_row_bits = fb[req.row_select];
                default: begin
                    clear_machine();
                    pc = start_addr;
                end
            endcase
            r.pc_value = pc;
            r.index_value = ireg;
            r.flag_value = v[15];
            pending.push_back(r);
        endfunction

        function void check_result(t_out got);
            t_out exp_r;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.pc_value !== exp_r.pc_value)
                $display("%0t: pc expected %h actual %h", $time, exp_r.pc_value, got.pc_value);
            if (got.index_value !== exp_r.index_value)
                $display("%0t: index expected %h actual %h", $time, exp_r.index_value,
                         got.index_value);
            if (got.flag_value !== exp_r.flag_value)
                $display("%0t: flag expected %h actual %h", $time, exp_r.flag_value,
                         got.flag_value);
            if (got.screen_row_bits !== exp_r.screen_row_bits)
                $display("%0t: row expected %h actual %h", $time, exp_r.screen_row_bits,
                         got.screen_row_bits);
            if (got.status !== exp_r.status)
                $display("%0t: status expected %0d actual %0d", $time, exp_r.status,
                         got.status);
            if (got !== exp_r) errors++;
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    t_in         req;
    logic        res_valid;
    logic        res_stall;
    t_out        res;
    logic        cfg_we;
    logic [11:0] cfg_wdata;

    c8_scoreboard sb;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          quiet_cycles;
    bit          written [4096];
    logic [11:0] prog_ptr;

    chip8_instruction_core u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_valid    (req_valid),
        .o_stall    (req_stall),
        .i_req      (req),
        .o_valid    (res_valid),
        .i_stall    (res_stall),
        .o_res      (res),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata)
    );

    always begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    always @(posedge clk) begin
        if (rst_n && req_valid && !req_stall) sb.note_request(req);
        if (rst_n && res_valid && !res_stall) sb.check_result(res);
        if ((req_valid && !req_stall) || (res_valid && !res_stall) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 5000) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(negedge clk) begin
        res_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic send(input t_cmd c, input logic [11:0] a, input logic [7:0] d,
                        input logic [4:0] r);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) @(negedge clk);
        req_valid <= 1'b1;
        req.cmd <= c;
        req.load_address <= a;
        req.load_data <= d;
        req.row_select <= r;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        @(negedge clk);
        req_valid <= 1'b0;
        req <= t_in'($urandom());
    endtask

    task automatic load_byte(input logic [11:0] a, input logic [7:0] d);
        written[a] = 1'b1;
        send(CMD_LOAD, a, d, 5'($urandom()));
    endtask

    // Memory reads by draw and block load must land on written bytes.
    task automatic prepare_reads(input logic [15:0] op);
        int span;
        span = 0;
        if (op[15:12] == 4'hD) span = op[3:0];
        if (op[15:12] == 4'hF && op[7:0] == 8'h65) span = op[11:8] + 1;
        for (int k = 0; k < span; k++)
            if (!written[sb.ireg + k[11:0]]) load_byte(sb.ireg + k[11:0], 8'($urandom()));
    endtask

    // Places one instruction at the current PC and executes it.
    task automatic exec_op(input logic [15:0] op);
        logic [11:0] p;
        prepare_reads(op);
        p = sb.pc;
        load_byte(p, op[15:8]);
        load_byte(p + 12'd1, op[7:0]);
        send(CMD_EXEC, 12'($urandom()), 8'($urandom()), 5'($urandom()));
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_start(input logic [11:0] a);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= a;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.start_addr = a;
        send(CMD_RESTART, 12'($urandom()), 8'($urandom()), 5'($urandom()));
    endtask

    // Picks a random opcode; memory it reads is made written by prepare_reads in exec_op.
    function automatic logic [15:0] random_op();
        logic [3:0] x, y, n;
        logic [7:0] nn;
        x = 4'($urandom());
        y = 4'($urandom());
        n = 4'($urandom());
        nn = 8'($urandom());
        case ($urandom_range(19))
            0: return 16'h00E0;
            1: return 16'h00EE;
            2: return {4'h0, 4'($urandom_range(15)), nn};
            3: return {4'h2, 12'($urandom())};
            4: return {4'h3, x, nn};
            5: return {4'h4, x, nn};
            6: return {4'h5, x, y, n};
            7: return {4'h9, x, y, n};
            8, 9: return {4'h6, x, nn};
            10: return {4'h7, x, nn};
            11, 12: return {4'h8, x, y, n};
            13: return {4'hA, 12'($urandom_range(4095))};
            14: return {4'hC, x, nn};
            15, 16: return {4'hD, x, y, n};
            17: return {4'hE, x, ($urandom_range(2) == 0) ? 8'h9E :
                                  ($urandom_range(1) ? 8'hA1 : nn)};
            18: return {4'hF, x, nn};
            default: return {4'hF, x, 8'h1E};
        endcase
    endfunction

    task automatic random_phase(input int count);
        logic [15:0] op;
        for (int k = 0; k < count; k++) begin
            case ($urandom_range(9))
                0: load_byte(12'($urandom()), 8'($urandom()));
                1: send(CMD_READ, 12'($urandom()), 8'($urandom()), 5'($urandom()));
                default: begin
                    op = random_op();
                    exec_op(op);
                end
            endcase
            if ($urandom_range(99) == 0)
                send(CMD_RESTART, 12'($urandom()), 8'($urandom()), 5'($urandom()));
        end
    endtask

    initial begin
        sb = new();
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        res_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 12'h0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        quiet_cycles = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        load_byte(12'hFFF, 8'hFF);
        load_byte(12'h000, 8'h00);
        send(CMD_READ, 12'h0, 8'h0, 5'd31);
        exec_op(16'h60FF);
        exec_op(16'h6101);
        exec_op(16'h8014);
        exec_op(16'h8015);
        exec_op(16'h8F17);
        exec_op(16'h8FE6);
        exec_op(16'h00EE);
        exec_op(16'h0123);
        exec_op(16'h8008);
        exec_op(16'hC0FF);
        exec_op(16'hAFFE);
        exec_op(16'hF033);
        exec_op(16'hF165);
        exec_op(16'h603F);
        exec_op(16'h611E);
        exec_op(16'hD01F);
        exec_op(16'hD010);
        send(CMD_READ, 12'h0, 8'h0, 5'd30);
        exec_op(16'hF555);
        exec_op(16'hF0FF);
        exec_op(16'hB0FF);
        for (int k = 0; k < 17; k++) exec_op({4'h2, sb.pc + 12'd2});
        send(CMD_RESTART, 12'h0, 8'h0, 5'd0);

        set_start(12'hFFE);
        send_idle_pct = 76;
        random_phase(95);
        set_start(12'h000);
        send_idle_pct = 0;
        recv_stall_pct = 76;
        random_phase(95);
        set_start(12'($urandom()));
        send_idle_pct = 6;
        recv_stall_pct = 6;
        random_phase(95);
        set_start(12'd512);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        random_phase(95);

        drain();
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
